### hw/rtl/safc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package safc_pkg;
    localparam int TABLE_SETS = 1024;
    localparam int TABLE_WAYS = 4;
    localparam int COUNT_BITS = 16;
    localparam int SET_BITS = $clog2(TABLE_SETS);
    localparam int WAY_BITS = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] REG_WATCHED_DST = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WATCHED_PORT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUDGET = 2'd3;
    localparam logic [15:0] ETHER_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        t_clear_st, t_idle_st, t_read_st, t_write_st, t_out_st
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read;
        logic write;
        logic show;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic needs_table;
    } t_status;

    typedef struct packed {
        logic [15:0] frame_type;
        logic [7:0]  ip_protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        counted;
        logic [15:0] source_count;
        logic        newly_blocked;
        logic        table_full;
        logic        budget_done;
    } t_out_item;
endpackage
`default_nettype wire

### hw/rtl/safc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface safc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/safc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module safc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire safc_pkg::t_status i_status,
    output safc_pkg::t_cmd       o_cmd
);
    import safc_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_clear_st;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_clear_st: if (i_status.clear_last) n_state = t_idle_st;
            t_idle_st: if (i_in_valid) n_state = t_read_st;
            t_read_st: n_state = i_status.needs_table ? t_write_st : t_out_st;
            t_write_st: n_state = t_out_st;
            t_out_st: begin
                if (i_out_ready) n_state = i_in_valid ? t_read_st : t_idle_st;
            end
            default: n_state = t_idle_st;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            t_clear_st: o_cmd.clear_step = 1'b1;
            t_idle_st: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            t_read_st: o_cmd.read = 1'b1;
            t_write_st: o_cmd.write = 1'b1;
            t_out_st: begin
                o_out_valid = 1'b1;
                o_cmd.show = 1'b1;
                o_in_ready = i_out_ready;
                o_cmd.load = i_out_ready & i_in_valid;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/safc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module safc_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire safc_pkg::t_cmd     i_cmd,
    output safc_pkg::t_status       o_status,
    input  wire safc_pkg::t_in_item i_item,
    output safc_pkg::t_out_item     o_item,
    input  wire logic               i_cfg_we,
    input  wire logic [safc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [safc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import safc_pkg::*;
    localparam int EBITS = 1 + 32 + COUNT_BITS;

    logic [31:0] r_watched_dst;
    logic [15:0] r_watched_port, r_limit, r_budget, r_seen;
    t_in_item r_item;
    t_out_item r_res;
    logic [SET_BITS-1:0] r_clr_idx;

    // each row holds all ways of one set: valid, address, count
    logic [TABLE_WAYS*EBITS-1:0] r_mem [TABLE_SETS];
    logic [TABLE_WAYS*EBITS-1:0] r_row;
    logic [TABLE_WAYS*EBITS-1:0] r_wr_row;
    logic [SET_BITS-1:0] r_set;
    logic r_do_write;

    logic [15:0] fold;
    logic [SET_BITS-1:0] set_idx;
    logic qualifies, exhausted, to_table;
    assign fold = r_item.src_addr[31:16] ^ r_item.src_addr[15:0];
    assign set_idx = SET_BITS'(fold % TABLE_SETS);
    assign exhausted = r_seen >= r_budget;
    assign qualifies = (r_item.src_port == r_watched_port)
                       || (r_item.dst_port == r_watched_port);
    assign to_table = !exhausted && qualifies && r_item.frame_type == ETHER_IPV4
                      && r_item.ip_protocol == PROTO_UDP && r_item.dst_addr == r_watched_dst;
    assign o_status.needs_table = to_table;
    assign o_status.clear_last = r_clr_idx == SET_BITS'(TABLE_SETS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watched_dst <= '0;
            r_watched_port <= 16'd53;
            r_limit <= 16'd120;
            r_budget <= 16'd5000;
            r_seen <= '0;
            r_clr_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WATCHED_DST: r_watched_dst <= i_cfg_data;
                    REG_WATCHED_PORT: r_watched_port <= i_cfg_data[15:0];
                    REG_LIMIT: r_limit <= i_cfg_data[15:0];
                    REG_BUDGET: r_budget <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_step) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cmd.read && !exhausted && qualifies) r_seen <= r_seen + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.read) r_set <= set_idx;
    end

    // table memory: registered read, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) r_mem[r_clr_idx] <= '0;
        else if (r_do_write) r_mem[r_set] <= r_wr_row;
        r_row <= r_mem[set_idx];
    end

    // lookup on the row read in the read state
    logic hit, free_found;
    logic [WAY_BITS-1:0] hit_way, free_way;
    logic [COUNT_BITS-1:0] old_cnt, new_cnt;
    logic [TABLE_WAYS*EBITS-1:0] upd_row;
    always_comb begin
        hit = 1'b0; free_found = 1'b0; hit_way = '0; free_way = '0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (r_row[w*EBITS + EBITS-1]) begin
                if (!hit && r_row[w*EBITS + COUNT_BITS +: 32] == r_item.src_addr) begin
                    hit = 1'b1; hit_way = WAY_BITS'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1; free_way = WAY_BITS'(w);
            end
        end
        old_cnt = r_row[hit_way*EBITS +: COUNT_BITS];
        new_cnt = hit ? ((old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1)
                      : COUNT_BITS'(1);
        upd_row = r_row;
        if (hit) upd_row[hit_way*EBITS +: COUNT_BITS] = new_cnt;
        else upd_row[free_way*EBITS +: EBITS] = {1'b1, r_item.src_addr, new_cnt};
    end

    // counts compared and reported at 32 bits so any count width up to 32 works
    logic [31:0] old_wide, new_wide;
    assign old_wide = 32'(old_cnt);
    assign new_wide = 32'(new_cnt);

    // result set in read state, then completed in write state (table path)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_do_write <= 1'b0;
        else r_do_write <= i_cmd.write && (hit || free_found);
        if (i_cmd.write) r_wr_row <= upd_row;
        if (i_cmd.read) begin
            // accepted, counted, source_count, newly_blocked, table_full, budget_done
            r_res <= {!exhausted && qualifies, 1'b0, 16'd0, 1'b0, 1'b0, exhausted};
        end else if (i_cmd.write) begin
            r_res.counted <= hit || free_found;
            r_res.table_full <= !hit && !free_found;
            r_res.source_count <= !(hit || free_found) ? 16'd0
                                  : (new_wide > 32'h0000_FFFF) ? 16'hFFFF : new_wide[15:0];
            r_res.newly_blocked <= hit ? (old_cnt != COUNT_MAX && old_wide == 32'(r_limit))
                                       : (free_found && r_limit == 16'd0);
        end
    end
    assign o_item = r_res;
endmodule
`default_nettype wire

### hw/rtl/source_address_flood_counter_core.sv
// source_address_flood_counter_core
// Counts UDP packets per source address toward a watched destination.
// Channels: in_ch carries one parsed header per transfer, out_ch one result
// per input item. Configuration through a plain write port (index, data),
// written by the user only while the block is idle (not enforced by the block).
// Result: items that do not touch the table go from the row read straight
// to the output; items that do pass the row read, then the update of one
// set row of the table memory, before the result.
// One item is in work at a time; the next one waits for the registered
// set row read and, for table items, the update before the result.
// Reset: synchronous, active low. After reset the block clears the table
// one set per cycle, with input ready low; configuration writes are taken
// during that pass.
// A stalled receiver holds the result; the next input is taken in the same
// cycle as the result transfer.
`timescale 1ns / 1ps
`default_nettype none
module source_address_flood_counter_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    safc_if.sink      in_ch,
    safc_if.source    out_ch,
    input  wire logic i_cfg_we,
    input  wire logic [safc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [safc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import safc_pkg::*;
    t_cmd cmd;
    t_status status;

    safc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(status), .o_cmd(cmd)
    );

    safc_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_item(in_ch.payload), .o_item(out_ch.payload),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.payload.budget_done |-> !out_ch.payload.accepted)
        else $error("ignored item reported as accepted");
    a_count_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.payload.counted |-> out_ch.payload.accepted
        && !out_ch.payload.table_full)
        else $error("counted without acceptance");
    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.read || cmd.write) |-> !in_ch.ready)
        else $error("input taken while item in work");
endmodule
`default_nettype wire
